@@ rtl/sbeu_pkg.sv @@
// Shared constants, opcodes, status codes and state type for the stack bytecode execute unit.
// Depends on nothing; sbeu_if, sbeu_divider and the top level import it.
`timescale 1ns / 1ps

package sbeu_pkg;

   localparam int STACK_DEPTH  = 256;
   localparam int GLOBAL_SLOTS = 256;
   localparam int SP_W         = $clog2(STACK_DEPTH);
   localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
   localparam int GI_W         = $clog2(GLOBAL_SLOTS);
   localparam int DATA_W       = 32;
   localparam int PC_W         = 16;
   localparam int OP_W         = 5;

   localparam logic [OP_W-1:0] OP_CONST   = 5'd0;
   localparam logic [OP_W-1:0] OP_ADD     = 5'd1;
   localparam logic [OP_W-1:0] OP_SUB     = 5'd2;
   localparam logic [OP_W-1:0] OP_MUL     = 5'd3;
   localparam logic [OP_W-1:0] OP_DIV     = 5'd4;
   localparam logic [OP_W-1:0] OP_EQ      = 5'd5;
   localparam logic [OP_W-1:0] OP_GT      = 5'd6;
   localparam logic [OP_W-1:0] OP_LT      = 5'd7;
   localparam logic [OP_W-1:0] OP_EMIT    = 5'd8;
   localparam logic [OP_W-1:0] OP_READ    = 5'd9;
   localparam logic [OP_W-1:0] OP_DEFGLOB = 5'd10;
   localparam logic [OP_W-1:0] OP_GETGLOB = 5'd11;
   localparam logic [OP_W-1:0] OP_SETGLOB = 5'd12;
   localparam logic [OP_W-1:0] OP_POP     = 5'd13;
   localparam logic [OP_W-1:0] OP_JUMP    = 5'd14;
   localparam logic [OP_W-1:0] OP_JFALSE  = 5'd15;
   localparam logic [OP_W-1:0] OP_LOOP    = 5'd16;
   localparam logic [OP_W-1:0] OP_EXIT    = 5'd17;
   localparam logic [OP_W-1:0] OP_START   = 5'd18;

   typedef enum logic [2:0] {
      ST_RUN      = 3'd0,
      ST_RET      = 3'd1,
      ST_UNDER    = 3'd2,
      ST_OVER     = 3'd3,
      ST_DIVZ     = 3'd4,
      ST_UNDEF_RD = 3'd5,
      ST_UNDEF_WR = 3'd6,
      ST_HALTED   = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DIV
   } state_type;

endpackage

@@ rtl/sbeu_if.sv @@
// Valid/ready channel interfaces for instruction words and result words.
// Depends on sbeu_pkg for field widths.
`timescale 1ns / 1ps

interface sbeu_req_if import sbeu_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          op;
   logic signed [DATA_W-1:0] value_in;
   logic [GI_W-1:0]          global_index;
   logic [PC_W-1:0]          jump_offset;

   modport source (output valid, op, value_in, global_index, jump_offset, input ready);
   modport sink   (input valid, op, value_in, global_index, jump_offset, output ready);
endinterface

interface sbeu_rsp_if import sbeu_pkg::*; ;
   logic                     valid;
   logic                     ready;
   logic [2:0]               status;
   logic                     print_valid;
   logic signed [DATA_W-1:0] print_value;
   logic [PC_W-1:0]          next_pc;

   modport source (output valid, status, print_valid, print_value, next_pc, input ready);
   modport sink   (input valid, status, print_valid, print_value, next_pc, output ready);
endinterface

@@ rtl/sbeu_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sbeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/sbeu_divider.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on sbeu_pkg for the data width.
`timescale 1ns / 1ps

module sbeu_divider import sbeu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DATA_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DATA_W:0]   rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   rem_shift;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = done_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_in    = neg_ff;
      rem_shift = {rem_ff[DATA_W-1:0], quo_ff[DATA_W-1]};
      if (start) begin
         // Work on magnitudes; the most negative value still fits unsigned.
         busy_in = 1'b1;
         done_in = 1'b0;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
         dvs_in  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = rem_shift - {1'b0, dvs_ff};
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

endmodule

@@ rtl/stack_bytecode_execute_unit.sv @@
// Top level of the stack bytecode execute unit: control, top-of-stack register, memories.
// Depends on sbeu_pkg, sbeu_if, sbeu_ram and sbeu_divider.
//
// Usage: each word on the req channel is one decoded instruction (op, value_in,
// global_index, jump_offset); each instruction yields exactly one word on the rsp
// channel (status, print_valid, print_value, next_pc), in order.
// The operand stack sits in a synchronous RAM with the top entry held in a
// register; globals sit in a second RAM with a defined flag per slot in flip-flops.
// An accepted instruction reads both RAMs at the accepting edge and executes and
// writes back in the execute step that follows; its result word is then registered
// in the output register, and no new word is taken until the unit is idle again.
// A divide starts the one-bit-per-cycle divider and waits in the divide step until
// the quotient is done. A result waits in the output register while the receiver
// stalls; an instruction that finishes meanwhile holds in its execute or divide
// step until that register frees.
// Reset empties the stack, clears all defined flags, pc and the halted flag; it
// takes effect at once with no clearing pass.
`timescale 1ns / 1ps

module stack_bytecode_execute_unit import sbeu_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   sbeu_req_if.sink   req,
   sbeu_rsp_if.source rsp
);

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff;
   logic [DATA_W-1:0] value_ff;
   logic [GI_W-1:0]   gi_ff;
   logic [PC_W-1:0]   off_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [PC_W-1:0]   pc_ff, pc_in;
   logic              halted_ff, halted_in;
   logic [GLOBAL_SLOTS-1:0] defined_ff;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic              rsp_pvalid_ff;
   logic [DATA_W-1:0] rsp_pvalue_ff;
   logic [PC_W-1:0]   rsp_pc_ff;

   logic              accept, fire, out_free, div_go, div_done;
   logic [DATA_W-1:0] stk_rd, glb_rd, quotient, bin_res;
   logic              stk_we, glb_we, def_set;
   status_type        st;
   logic              pvld;
   logic [DATA_W-1:0] pval;
   logic [PC_W-1:0]   len, pc_adv;
   logic [CNT_W-1:0]  rd_idx;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign rd_idx   = count_ff - CNT_W'(2);
   assign div_go   = (state_ff == S_EXEC) && !halted_ff && (op_ff == OP_DIV)
                     && (count_ff >= CNT_W'(2)) && (tos_ff != '0);

   sbeu_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (SP_W'(count_ff - CNT_W'(1))),
      .wr_data (tos_ff),
      .rd_en   (accept),
      .rd_addr (rd_idx[SP_W-1:0]),
      .rd_data (stk_rd)
   );

   sbeu_ram #(.WIDTH(DATA_W), .DEPTH(GLOBAL_SLOTS)) u_global_ram (
      .clock   (clock),
      .wr_en   (glb_we),
      .wr_addr (gi_ff),
      .wr_data (tos_ff),
      .rd_en   (accept),
      .rd_addr (req.global_index),
      .rd_data (glb_rd)
   );

   sbeu_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (stk_rd),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (div_go) state_in = S_DIV;
            else if (out_free) state_in = S_IDLE;
         end
         S_DIV: begin
            if (div_done && out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req.ready = 1'b0;
      fire      = 1'b0;
      case (state_ff)
         S_IDLE: req.ready = 1'b1;
         S_EXEC: fire = !div_go && out_free;
         S_DIV:  fire = div_done && out_free;
         default: ;
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_ADD:  bin_res = stk_rd + tos_ff;
         OP_SUB:  bin_res = stk_rd - tos_ff;
         OP_MUL:  bin_res = stk_rd * tos_ff;
         OP_DIV:  bin_res = quotient;
         OP_EQ:   bin_res = DATA_W'(stk_rd == tos_ff);
         OP_GT:   bin_res = DATA_W'($signed(stk_rd) > $signed(tos_ff));
         default: bin_res = DATA_W'($signed(stk_rd) < $signed(tos_ff));
      endcase
   end

   always_comb begin
      case (op_ff)
         OP_CONST, OP_DEFGLOB, OP_GETGLOB, OP_SETGLOB: len = PC_W'(2);
         OP_JUMP, OP_JFALSE, OP_LOOP:                 len = PC_W'(3);
         default:                                     len = PC_W'(1);
      endcase
   end

   assign pc_adv = pc_ff + len;

   // Effects of the instruction held in the execute step.
   always_comb begin
      count_in  = count_ff;
      tos_in    = tos_ff;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      st        = ST_RUN;
      pvld      = 1'b0;
      pval      = '0;
      stk_we    = 1'b0;
      glb_we    = 1'b0;
      def_set   = 1'b0;
      if (op_ff == OP_START) begin
         count_in  = '0;
         pc_in     = '0;
         halted_in = 1'b0;
      end else if (halted_ff) begin
         st = ST_HALTED;
      end else begin
         pc_in = pc_adv;
         case (op_ff)
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT, OP_LT: begin
               if (count_ff < CNT_W'(2)) st = ST_UNDER;
               else if (op_ff == OP_DIV && tos_ff == '0) st = ST_DIVZ;
               else begin
                  tos_in   = bin_res;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            OP_CONST, OP_READ: begin
               if (count_ff == CNT_W'(STACK_DEPTH)) st = ST_OVER;
               else begin
                  stk_we   = (count_ff != '0);
                  tos_in   = value_ff;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_GETGLOB: begin
               if (!defined_ff[gi_ff]) st = ST_UNDEF_RD;
               else if (count_ff == CNT_W'(STACK_DEPTH)) st = ST_OVER;
               else begin
                  stk_we   = (count_ff != '0);
                  tos_in   = glb_rd;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_EMIT, OP_DEFGLOB, OP_POP: begin
               if (count_ff == '0) st = ST_UNDER;
               else begin
                  // The entry below the top becomes the new top.
                  tos_in   = stk_rd;
                  count_in = count_ff - CNT_W'(1);
                  if (op_ff == OP_EMIT) begin
                     pvld = 1'b1;
                     pval = tos_ff;
                  end
                  if (op_ff == OP_DEFGLOB) begin
                     glb_we  = 1'b1;
                     def_set = 1'b1;
                  end
               end
            end
            OP_SETGLOB: begin
               if (!defined_ff[gi_ff]) st = ST_UNDEF_WR;
               else if (count_ff == '0) st = ST_UNDER;
               else glb_we = 1'b1;
            end
            OP_JUMP: pc_in = pc_adv + off_ff;
            OP_JFALSE: begin
               if (count_ff == '0) st = ST_UNDER;
               else if (tos_ff == '0) pc_in = pc_adv + off_ff;
            end
            OP_LOOP:   pc_in = pc_adv - off_ff;
            OP_EXIT:   st = ST_RET;
            default: ;
         endcase
         if (st != ST_RUN) halted_in = 1'b1;
      end
      if (!fire) begin
         stk_we  = 1'b0;
         glb_we  = 1'b0;
         def_set = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pc_ff        <= '0;
         halted_ff    <= 1'b0;
         defined_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            count_ff  <= count_in;
            pc_ff     <= pc_in;
            halted_ff <= halted_in;
         end
         if (def_set) defined_ff[gi_ff] <= 1'b1;
         if (fire) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         op_ff    <= req.op;
         value_ff <= req.value_in;
         gi_ff    <= req.global_index;
         off_ff   <= req.jump_offset;
      end
      if (fire) begin
         tos_ff        <= tos_in;
         rsp_status_ff <= st;
         rsp_pvalid_ff <= pvld;
         rsp_pvalue_ff <= pval;
         rsp_pc_ff     <= pc_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.print_valid = rsp_pvalid_ff;
   assign rsp.print_value = rsp_pvalue_ff;
   assign rsp.next_pc     = rsp_pc_ff;

`ifndef NO_ASSERTIONS
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted word did not enter execute");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");
   a_fire_free: assert property (@(posedge clock) disable iff (reset)
      fire |-> out_free)
      else $error("result written over a waiting word");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_go |=> (state_ff == S_DIV) && !rsp_valid_ff || (state_ff == S_DIV))
      else $error("divide did not enter its wait step");
`endif

endmodule
